// File: rtl/fprt_pkg.sv
// Shared types and constants of the fixed-priority response-time block.
`timescale 1ns / 1ps
`default_nettype none
package fprt_pkg;
   localparam int MAX_TASKS   = 32;
   localparam int IDX_W       = $clog2(MAX_TASKS);
   localparam int CNT_W       = $clog2(MAX_TASKS + 1);
   localparam int TIME_W      = 32;
   localparam int PRIO_W      = 8;
   localparam int PART_W      = 4;
   localparam int NUM_W       = 34;
   localparam int BOUND_W     = 33;
   localparam int STEP_W      = 6;
   localparam int FAIL_MARGIN = 100;

   typedef struct packed {
      logic [PART_W-1:0] partition;
      logic [PRIO_W-1:0] priority_lvl;
      logic [TIME_W-1:0] blocking;
      logic [TIME_W-1:0] jitter;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] wcet;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SELF_RD,
      ST_SELF_GET,
      ST_PASS,
      ST_RD,
      ST_CHK,
      ST_TERM,
      ST_NEXT,
      ST_END,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// File: rtl/fprt_table.sv
// Task table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module fprt_table (
   input  wire                             clock,
   input  wire                             wr_en,
   input  wire  [fprt_pkg::IDX_W-1:0]      wr_addr,
   input  fprt_pkg::entry_type             wr_data,
   input  wire  [fprt_pkg::IDX_W-1:0]      rd_addr,
   output fprt_pkg::entry_type             rd_data
);
   fprt_pkg::entry_type mem [fprt_pkg::MAX_TASKS];
   fprt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: rtl/fprt_term.sv
// Bit-serial divide and saturating multiply: min(cost * floor(num / per), cap).
`timescale 1ns / 1ps
`default_nettype none
module fprt_term (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire  [fprt_pkg::NUM_W-1:0]        num,
   input  wire  [fprt_pkg::TIME_W-1:0]       per,
   input  wire  [fprt_pkg::TIME_W-1:0]       cost,
   input  wire  [fprt_pkg::BOUND_W-1:0]      cap,
   output logic                              done,
   output logic [fprt_pkg::BOUND_W-1:0]      term
);
   localparam int W = fprt_pkg::TIME_W;
   localparam int B = fprt_pkg::BOUND_W;

   logic [fprt_pkg::NUM_W-1:0]  num_ff;
   logic [W-1:0]                rem_ff, per_ff, cost_ff;
   logic [B-1:0]                acc_ff, cap_ff;
   logic [fprt_pkg::STEP_W-1:0] cnt_ff;
   logic                        busy_ff, done_ff;

   logic [W:0]   rem_sh;
   logic         qbit;
   logic [W-1:0] rem_in;
   logic [B+1:0] acc_sum;
   logic [B-1:0] acc_in;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[fprt_pkg::NUM_W-1]};
      qbit    = rem_sh >= {1'b0, per_ff};
      rem_in  = qbit ? W'(rem_sh - {1'b0, per_ff}) : rem_sh[W-1:0];
      acc_sum = {1'b0, acc_ff, 1'b0} + (qbit ? (B+2)'(cost_ff) : '0);
      acc_in  = (acc_sum > (B+2)'(cap_ff)) ? cap_ff : acc_sum[B-1:0];
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff  <= num;
         rem_ff  <= '0;
         acc_ff  <= '0;
         per_ff  <= per;
         cost_ff <= cost;
         cap_ff  <= cap;
         cnt_ff  <= fprt_pkg::STEP_W'(fprt_pkg::NUM_W - 1);
      end else if (busy_ff) begin
         num_ff <= {num_ff[fprt_pkg::NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0) && !start;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done = done_ff;
   assign term = acc_ff;
endmodule
`default_nettype wire

// File: rtl/fixed_priority_response_time_top.sv
// Top level: fixed-priority response-time analysis with release jitter.
//
//  channel | dir | tdata                                   | tuser
//  req_    | in  | index, wcet, period, deadline, jitter,   | req_type
//          |     | blocking, priority, partition           |
//  rsp_    | out | wcrt                                    | converged
//  csr_    | in  | task_count (write only)                 | -
//
// An analysis runs passes over the table; each pass reads the first n entries,
// n = task_count capped at MAX_TASKS, and computes a term for each of the h
// higher-priority tasks on the same partition; the serial divider makes one
// quotient bit per cycle.
// One word at a time; reset is synchronous and clears control state only.
// A finished result waits in the output register while rsp_tready is low.
`timescale 1ns / 1ps
`default_nettype none
module fixed_priority_response_time_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // index[4:0] wcet[36:5] period[68:37] deadline[100:69] jitter[132:101]
   // blocking[164:133] priority_req[172:165] partition[176:173], zero fill
   input  wire  [183:0] req_tdata,
   // req_type[0]
   input  wire          req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // wcrt[32:0], zero fill
   output logic [39:0]  rsp_tdata,
   // converged[0]
   output logic         rsp_tuser,
   input  wire          csr_we,
   input  wire  [5:0]   csr_wdata
);
   localparam int W = fprt_pkg::TIME_W;
   localparam int B = fprt_pkg::BOUND_W;
   localparam int N = fprt_pkg::NUM_W;

   fprt_pkg::state_type state_ff, state_in;
   fprt_pkg::entry_type wr_entry, rd_entry;

   logic [5:0]                   count_ff;
   logic [fprt_pkg::CNT_W-1:0]   used;
   logic [fprt_pkg::IDX_W-1:0]   idx_ff, rd_addr;
   logic [fprt_pkg::CNT_W-1:0]   k_ff;
   logic [W-1:0]                 dl_ff, jit_ff;
   logic [fprt_pkg::PRIO_W-1:0]  prio_ff;
   logic [fprt_pkg::PART_W-1:0]  part_ff;
   logic [N-1:0]                 start_ff, sum_ff;
   logic [B-1:0]                 r_ff, cap, res_ff, out_ff;
   logic                         conv_ff, out_conv_ff, rsp_valid_ff;
   logic                         accept, analyze_ok, load_wr, hp, self_fail;
   logic                         term_start, term_done, last_k, out_load;
   logic [B-1:0]                 term;
   logic [W-1:0]                 per_eff;
   logic [N-1:0]                 num, self_start;
   logic [N:0]                   sum_add, demand_raw;
   logic [B-1:0]                 demand;

   assign accept = req_tvalid && req_tready;
   assign used   = (count_ff > 6'(fprt_pkg::MAX_TASKS)) ?
                   fprt_pkg::CNT_W'(fprt_pkg::MAX_TASKS) : fprt_pkg::CNT_W'(count_ff);
   assign analyze_ok = fprt_pkg::CNT_W'(req_tdata[4:0]) < used;
   assign load_wr = accept && !req_tuser;
   assign cap = {1'b0, dl_ff} + B'(1);

   assign wr_entry.wcet         = req_tdata[36:5];
   assign wr_entry.period       = req_tdata[68:37];
   assign wr_entry.deadline     = req_tdata[100:69];
   assign wr_entry.jitter       = req_tdata[132:101];
   assign wr_entry.blocking     = req_tdata[164:133];
   assign wr_entry.priority_lvl = req_tdata[172:165];
   assign wr_entry.partition    = req_tdata[176:173];

   fprt_table u_table (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (req_tdata[4:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   always_comb begin
      per_eff    = (rd_entry.period == '0) ? W'(1) : rd_entry.period;
      num        = N'(r_ff) + N'(rd_entry.jitter) + N'(per_eff) - N'(1);
      hp         = (rd_entry.priority_lvl < prio_ff) && (rd_entry.partition == part_ff);
      self_start = N'(rd_entry.blocking) + N'(rd_entry.wcet);
      self_fail  = self_start > N'(rd_entry.deadline);
      sum_add    = {1'b0, sum_ff} + (N+1)'(term);
      demand_raw = {1'b0, start_ff} + {1'b0, sum_ff};
      demand     = (demand_raw > (N+1)'(cap)) ? cap : demand_raw[B-1:0];
      last_k     = (k_ff + 1'b1) == used;
      out_load   = !rsp_valid_ff || rsp_tready;
   end

   fprt_term u_term (
      .clock (clock),
      .reset (reset),
      .start (term_start),
      .num   (num),
      .per   (per_eff),
      .cost  (rd_entry.wcet),
      .cap   (cap),
      .done  (term_done),
      .term  (term)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fprt_pkg::ST_IDLE:
            if (accept && req_tuser && analyze_ok) state_in = fprt_pkg::ST_SELF_RD;
         fprt_pkg::ST_SELF_RD:  state_in = fprt_pkg::ST_SELF_GET;
         fprt_pkg::ST_SELF_GET:
            state_in = self_fail ? fprt_pkg::ST_DONE : fprt_pkg::ST_PASS;
         fprt_pkg::ST_PASS:     state_in = fprt_pkg::ST_RD;
         fprt_pkg::ST_RD:       state_in = fprt_pkg::ST_CHK;
         fprt_pkg::ST_CHK:
            state_in = hp ? fprt_pkg::ST_TERM : fprt_pkg::ST_NEXT;
         fprt_pkg::ST_TERM:
            if (term_done) state_in = fprt_pkg::ST_NEXT;
         fprt_pkg::ST_NEXT:
            state_in = last_k ? fprt_pkg::ST_END : fprt_pkg::ST_RD;
         fprt_pkg::ST_END:
            state_in = (demand == r_ff || demand > B'(dl_ff)) ?
                       fprt_pkg::ST_DONE : fprt_pkg::ST_PASS;
         fprt_pkg::ST_DONE:
            if (out_load) state_in = fprt_pkg::ST_IDLE;
         default:               state_in = fprt_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_tready = 1'b0;
      term_start = 1'b0;
      rd_addr    = k_ff[fprt_pkg::IDX_W-1:0];
      unique case (state_ff)
         fprt_pkg::ST_IDLE:    req_tready = 1'b1;
         fprt_pkg::ST_SELF_RD: rd_addr = idx_ff;
         fprt_pkg::ST_CHK:     term_start = hp;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fprt_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (state_ff == fprt_pkg::ST_DONE && out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= req_tdata[4:0];
      end
      unique case (state_ff)
         fprt_pkg::ST_SELF_GET: begin
            dl_ff    <= rd_entry.deadline;
            jit_ff   <= rd_entry.jitter;
            prio_ff  <= rd_entry.priority_lvl;
            part_ff  <= rd_entry.partition;
            start_ff <= self_start;
            r_ff     <= self_start[B-1:0];
            res_ff   <= B'(rd_entry.deadline) + B'(fprt_pkg::FAIL_MARGIN);
            conv_ff  <= 1'b0;
         end
         fprt_pkg::ST_PASS: begin
            sum_ff <= '0;
            k_ff   <= '0;
         end
         fprt_pkg::ST_TERM:
            if (term_done) begin
               sum_ff <= (sum_add > (N+1)'(cap)) ? N'(cap) : sum_add[N-1:0];
            end
         fprt_pkg::ST_NEXT: k_ff <= k_ff + 1'b1;
         fprt_pkg::ST_END: begin
            r_ff <= demand;
            if (demand == r_ff) begin
               res_ff  <= r_ff + B'(jit_ff);
               conv_ff <= 1'b1;
            end else begin
               res_ff  <= B'(dl_ff) + B'(fprt_pkg::FAIL_MARGIN);
               conv_ff <= 1'b0;
            end
         end
         fprt_pkg::ST_DONE:
            if (out_load) begin
               out_ff      <= res_ff;
               out_conv_ff <= conv_ff;
            end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff};
   assign rsp_tuser  = out_conv_ff;
endmodule
`default_nettype wire

// File: tb/tb_fixed_priority_response_time_top.sv
// Testbench for the fixed-priority response-time block: random task tables, checked bounds.
`timescale 1ns / 1ps
`default_nettype none
module tb_fixed_priority_response_time_top;
   localparam bit REQ_LOAD    = 1'b0;
   localparam bit REQ_ANALYZE = 1'b1;
   localparam int PASS_LIMIT  = 20;
   localparam int DRAIN_WAIT  = 40;

   class rta_scoreboard;
      fprt_pkg::entry_type ent[fprt_pkg::MAX_TASKS];
      bit           loaded[fprt_pkg::MAX_TASKS];
      int unsigned  count;
      logic [33:0]  bound_q[$];
      int           mismatches;
      int           results;

      function new();
         count = 0;
         mismatches = 0;
         results = 0;
         foreach (loaded[k]) loaded[k] = 1'b0;
      endfunction

      function int unsigned in_use();
         return (count > fprt_pkg::MAX_TASKS) ? fprt_pkg::MAX_TASKS : count;
      endfunction

      // fixed-point iteration; returns passes used, PASS_LIMIT+1 if it would run longer
      function int iterate(int i, output logic [32:0] bound, output bit conv);
         logic [63:0] dl, cap, start, r, sum, demand, t, q, c, term;
         int passes;
         dl = 64'(ent[i].deadline);
         cap = dl + 64'd1;
         start = 64'(ent[i].blocking) + 64'(ent[i].wcet);
         r = start;
         passes = 0;
         while (r <= dl) begin
            passes++;
            if (passes > PASS_LIMIT) return passes;
            sum = 0;
            for (int k = 0; k < int'(in_use()); k++) begin
               if (ent[k].priority_lvl < ent[i].priority_lvl &&
                   ent[k].partition == ent[i].partition) begin
                  t = (ent[k].period != 0) ? 64'(ent[k].period) : 64'd1;
                  q = (r + 64'(ent[k].jitter) + t - 64'd1) / t;
                  c = 64'(ent[k].wcet);
                  if (q != 0 && c > cap / q) term = cap;
                  else term = (c * q > cap) ? cap : c * q;
                  sum = sum + term;
                  if (sum > cap) sum = cap;
               end
            end
            demand = start + sum;
            if (demand > cap) demand = cap;
            if (demand == r) begin
               bound = 33'(r + 64'(ent[i].jitter));
               conv = 1'b1;
               return passes;
            end
            r = demand;
         end
         bound = 33'(dl + 64'(fprt_pkg::FAIL_MARGIN));
         conv = 1'b0;
         return passes;
      endfunction

      function void note_word(bit rtype, logic [4:0] idx, fprt_pkg::entry_type e);
         logic [32:0] b;
         bit cv;
         if (rtype == REQ_LOAD) begin
            ent[idx] = e;
            loaded[idx] = 1'b1;
         end else if (idx < in_use()) begin
            void'(iterate(int'(idx), b, cv));
            bound_q.push_back({cv, b});
         end
      endfunction

      function void check_word(logic [32:0] bound, logic conv);
         logic [33:0] exp_w;
         results++;
         if (bound_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result bound=%0d conv=%0b", bound, conv);
            return;
         end
         exp_w = bound_q.pop_front();
         if (exp_w[32:0] !== bound || exp_w[33] !== conv) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected bound=%0d conv=%0b, got bound=%0d conv=%0b",
                        exp_w[32:0], exp_w[33], bound, conv);
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   wire          req_tready;
   logic [183:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   wire          rsp_tvalid;
   logic         rsp_tready = 1'b0;
   wire  [39:0]  rsp_tdata;
   wire          rsp_tuser;
   logic         csr_we = 1'b0;
   logic [5:0]   csr_wdata = '0;

   rta_scoreboard sb = new();
   int gap_pct = 0;
   int stall_pct = 0;
   int words_sent = 0;
   int analyses = 0;

   fixed_priority_response_time_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata[32:0], rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   initial begin
      #400ms;
      $display("timeout");
      $display("tb_fixed_priority_response_time_top failed");
      $finish;
   end

   task automatic send_word(bit rtype, logic [4:0] idx, fprt_pkg::entry_type e);
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= rtype;
      req_tdata <= {7'd0, e, idx};
      do @(posedge clock); while (!req_tready);
      sb.note_word(rtype, idx, e);
      words_sent++;
      if (rtype == REQ_ANALYZE) analyses++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.bound_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_count(logic [5:0] v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.count = 32'(v);
   endtask

   function automatic fprt_pkg::entry_type sane_entry();
      fprt_pkg::entry_type e;
      e.wcet = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 30);
      e.period = ($urandom_range(19) == 0) ? 0 : $urandom_range(20, 300);
      e.deadline = $urandom_range(10, 800);
      e.jitter = $urandom_range(60);
      e.blocking = $urandom_range(20);
      e.priority_lvl = 8'($urandom_range(15));
      e.partition = 4'($urandom_range(3));
      return e;
   endfunction

   function automatic fprt_pkg::entry_type noise_entry();
      fprt_pkg::entry_type e;
      e.wcet = $urandom;
      e.period = $urandom;
      e.deadline = $urandom;
      e.jitter = $urandom;
      e.blocking = $urandom;
      e.priority_lvl = 8'($urandom);
      e.partition = 4'($urandom);
      return e;
   endfunction

   function automatic fprt_pkg::entry_type mk(logic [31:0] w, logic [31:0] p,
                                               logic [31:0] d, logic [31:0] j,
                                               logic [31:0] b, logic [7:0] pr,
                                               logic [3:0] pa);
      fprt_pkg::entry_type e;
      e = '{partition: pa, priority_lvl: pr, blocking: b, jitter: j, deadline: d,
            period: p, wcet: w};
      return e;
   endfunction

   task automatic random_phase(int n_words, logic [5:0] cnt, bit pause_mid);
      logic [32:0] b;
      bit cv;
      int idx;
      write_count(cnt);
      for (int k = 0; k < int'(sb.in_use()); k++)
         if (!sb.loaded[k]) send_word(REQ_LOAD, 5'(k), sane_entry());
      for (int n = 0; n < n_words; n++) begin
         if (pause_mid && n == n_words / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.bound_q.size() != 0) @(posedge clock);
         end
         if ($urandom_range(99) < 25) begin
            send_word(REQ_LOAD, 5'($urandom_range(31)),
                      ($urandom_range(99) < 15) ? noise_entry() : sane_entry());
         end else if (sb.in_use() == 0 || $urandom_range(99) < 10) begin
            idx = int'($urandom_range(31));
            if (idx < int'(sb.in_use()) && sb.iterate(idx, b, cv) > PASS_LIMIT)
               send_word(REQ_LOAD, 5'(idx), sane_entry());
            else send_word(REQ_ANALYZE, 5'(idx), noise_entry());
         end else begin
            idx = int'($urandom_range(sb.in_use() - 1));
            if (sb.iterate(idx, b, cv) > PASS_LIMIT) send_word(REQ_LOAD, 5'(idx), sane_entry());
            else send_word(REQ_ANALYZE, 5'(idx), noise_entry());
         end
      end
      drain();
   endtask

   initial begin
      logic [5:0] counts[6] = '{6'd32, 6'd5, 6'd1, 6'd17, 6'd0, 6'd32};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: count 0 ignores analysis, then a small table with corner cases
      send_word(REQ_ANALYZE, 5'd0, '0);
      drain();
      write_count(6'd4);
      send_word(REQ_LOAD, 5'd0, mk(32'd10, 32'd0, 32'd1000, 32'd5, 32'd0, 8'd1, 4'd2));
      send_word(REQ_LOAD, 5'd1, mk('1, '1, '1, '1, '1, 8'hFF, 4'hF));
      send_word(REQ_LOAD, 5'd2, mk(32'd3, 32'd50, 32'd200, 32'd7, 32'd2, 8'd5, 4'd2));
      send_word(REQ_LOAD, 5'd3, mk(32'd1, 32'd10, 32'd100, 32'd0, 32'd0, 8'd0, 4'd2));
      send_word(REQ_LOAD, 5'd31, '0);
      for (int i = 0; i < 6; i++) send_word(REQ_ANALYZE, i[4:0], '0);
      send_word(REQ_ANALYZE, 5'd31, '1);
      send_word(REQ_LOAD, 5'd2, mk(32'd0, 32'd1, 32'd0, '1, 32'd0, 8'd0, 4'd7));
      send_word(REQ_ANALYZE, 5'd2, '0);
      send_word(REQ_LOAD, 5'd1, mk(32'd4, 32'd20, 32'd60, 32'd3, 32'd1, 8'd9, 4'd2));
      send_word(REQ_ANALYZE, 5'd1, '0);
      send_word(REQ_LOAD, 5'd3, mk(32'd1, 32'd10, 32'd100, 32'd0, 32'd0, 8'd0, 4'hF));
      send_word(REQ_ANALYZE, 5'd0, '0);
      send_word(REQ_LOAD, 5'd20, noise_entry());
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 45; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 45; end
            default: begin gap_pct = 34; stall_pct = 34; end
         endcase
         random_phase(42, counts[ph], ph == 1);
      end
      write_count(6'd63);
      random_phase(20, 6'd63, 1'b0);

      $display("covered %0d words, %0d analyses, %0d results checked", words_sent, analyses,
               sb.results);
      $display("table sizes 0 to 63 with mixed gaps and stalls");
      if (sb.mismatches == 0 && sb.bound_q.size() == 0) begin
         $display("tb_fixed_priority_response_time_top passed");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches, sb.bound_q.size());
         $display("tb_fixed_priority_response_time_top failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
